FILE: sv/ple_pkg.sv
// Shared constants, codes and types for the positional list engine.
package ple_pkg;

	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int POS_W      = 7;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 3;
	localparam int VAL_W      = 32;

	// search reduction: groups of GRP_SIZE match bits
	localparam int GRP_SIZE = 8;
	localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
	localparam int GRP_W    = $clog2(GRP_SIZE);

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                  ins;
		logic                  del;
		logic [POS_W-1:0]      pos;
		logic [CNT_W-1:0]      count;
		logic [DATA_WIDTH-1:0] data;
	} cell_ctl_t;

endpackage

FILE: sv/ple_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares against the key.
module ple_cell (
	input  logic                           clk,
	input  ple_pkg::cell_ctl_t             ctl,
	input  logic [ple_pkg::IDX_W-1:0]      idx,
	input  logic [ple_pkg::DATA_WIDTH-1:0] left_data,
	input  logic [ple_pkg::DATA_WIDTH-1:0] right_data,
	output logic [ple_pkg::DATA_WIDTH-1:0] data,
	output logic                           match
);
	import ple_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic [POS_W-1:0]      idx_pos;
	logic [CNT_W-1:0]      idx_cnt;

	assign idx_pos = POS_W'(idx);
	assign idx_cnt = CNT_W'(idx);

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx_pos == ctl.pos) begin
				data_q <= ctl.data;
			end else if (idx_pos > ctl.pos) begin
				data_q <= left_data;
			end
		end else if (ctl.del && (idx_pos >= ctl.pos)) begin
			data_q <= right_data;
		end
	end

	assign data  = data_q;
	assign match = (idx_cnt < ctl.count) && (data_q == ctl.data);

endmodule

FILE: sv/ple_search.sv
// Two-stage registered priority encoder over the cells' match bits.
module ple_search (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ple_pkg::CAPACITY-1:0] match,
	output logic                         done,
	output logic                         found,
	output logic [ple_pkg::IDX_W-1:0]    index
);
	import ple_pkg::*;

	logic [NUM_GRP*GRP_SIZE-1:0] match_pad;
	logic [NUM_GRP-1:0]          grp_any;
	logic [GRP_W-1:0]            grp_sub [NUM_GRP];

	logic                        vld_s1;
	logic [NUM_GRP-1:0]          any_s1;
	logic [GRP_W-1:0]            sub_s1 [NUM_GRP];

	logic                        vld_s2;
	logic                        found_s2;
	logic [IDX_W-1:0]            index_s2;

	logic                        fin_found;
	logic [IDX_W-1:0]            fin_index;

	assign match_pad = (NUM_GRP*GRP_SIZE)'(match);

	// lowest set bit within each group
	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_any[g] = |match_pad[g*GRP_SIZE +: GRP_SIZE];
			grp_sub[g] = '0;
			for (int b = GRP_SIZE - 1; b >= 0; b--) begin
				if (match_pad[g*GRP_SIZE + b]) begin
					grp_sub[g] = GRP_W'(b);
				end
			end
		end
	end

	// lowest group with a hit
	always_comb begin
		fin_found = |any_s1;
		fin_index = '0;
		for (int g = NUM_GRP - 1; g >= 0; g--) begin
			if (any_s1[g]) begin
				fin_index = IDX_W'(g * GRP_SIZE) + IDX_W'(sub_s1[g]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			any_s1 <= grp_any;
			sub_s1 <= grp_sub;
		end
		if (vld_s1) begin
			found_s2 <= fin_found;
			index_s2 <= fin_index;
		end
	end

	assign done  = vld_s2;
	assign found = found_s2;
	assign index = index_s2;

endmodule

FILE: sv/positional_list_engine.sv
// Top level: command decode, cell chain, search reduction and result register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------
//  in       | in_valid / in_ready | command, position, value
//  out      | out_valid/out_ready | status, found_index, entry_count
//
// Insert and delete: all cells shift in the accepting edge.
// Search steps in order: compare and group encode, final encode, result load.
// One word is in flight at a time; a new word is taken in the cycle the result leaves.
// Reset clears the count and control; list contents are not cleared.
// A stalled result holds in_ready low until out_ready returns.
module positional_list_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ple_pkg::CMD_W-1:0]      command,
	input  logic [ple_pkg::POS_W-1:0]      position,
	input  logic signed [ple_pkg::VAL_W-1:0] value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ple_pkg::STAT_W-1:0]     status,
	output logic [ple_pkg::IDX_W-1:0]      found_index,
	output logic [ple_pkg::CNT_W-1:0]      entry_count
);
	import ple_pkg::*;

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_COMPARE = 2'd1;
	localparam logic [1:0] S_REDUCE  = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [DATA_WIDTH-1:0] key_q;

	logic                  out_valid_q;
	logic [STAT_W-1:0]     status_q;
	logic [IDX_W-1:0]      found_q;
	logic [CNT_W-1:0]      count_out_q;

	logic                  acc;
	logic                  is_full;
	logic                  is_empty;
	logic                  ins_ok;
	logic                  del_ok;
	logic [STAT_W-1:0]     imm_status;
	logic [CNT_W-1:0]      count_nxt;
	logic [POS_W-1:0]      count_pos;

	cell_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]   cell_match;

	logic                  srch_done;
	logic                  srch_found;
	logic [IDX_W-1:0]      srch_index;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign acc       = in_valid && in_ready;
	assign count_pos = POS_W'(count_q);
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign is_empty  = (count_q == '0);
	assign ins_ok    = (command == CMD_INSERT) && !is_full && (position <= count_pos);
	assign del_ok    = (command == CMD_DELETE) && !is_empty && (position < count_pos);

	always_comb begin
		case (command)
			CMD_INSERT: imm_status = is_full ? STAT_FULL :
				(position > count_pos) ? STAT_BADPOS : STAT_OK;
			CMD_DELETE: imm_status = is_empty ? STAT_EMPTY :
				(position >= count_pos) ? STAT_BADPOS : STAT_OK;
			default:    imm_status = STAT_BADPOS;
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (acc && ins_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (acc && del_ok) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_comb begin
		ctl.ins   = acc && ins_ok;
		ctl.del   = acc && del_ok;
		ctl.pos   = position;
		ctl.count = count_q;
		ctl.data  = (state_q == S_IDLE) ? DATA_WIDTH'(value) : key_q;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		ple_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.idx        (IDX_W'(i)),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.match      (cell_match[i])
		);
	end

	ple_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_COMPARE),
		.match  (cell_match),
		.done   (srch_done),
		.found  (srch_found),
		.index  (srch_index)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			case (state_q)
				S_IDLE: begin
					if (acc && (command == CMD_SEARCH)) begin
						state_q <= S_COMPARE;
					end
				end
				S_COMPARE: state_q <= S_REDUCE;
				S_REDUCE: begin
					if (srch_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if ((acc && (command != CMD_SEARCH)) || (state_q == S_REDUCE && srch_done)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (command == CMD_SEARCH)) begin
			key_q <= DATA_WIDTH'(value);
		end
		if (acc && (command != CMD_SEARCH)) begin
			status_q    <= imm_status;
			found_q     <= '0;
			count_out_q <= count_nxt;
		end else if (state_q == S_REDUCE && srch_done) begin
			status_q    <= srch_found ? STAT_OK : STAT_NOTFOUND;
			found_q     <= srch_found ? srch_index : '0;
			count_out_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign entry_count = count_out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("word accepted during search");

	a_done_in_reduce: assert property (@(posedge clk) disable iff (!arst_n)
		srch_done |-> (state_q == S_REDUCE))
		else $error("search result outside reduce state");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && ins_ok) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the list");

	a_search_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMPARE) |=> $stable(count_q))
		else $error("count changed during search");
`endif

endmodule
